@@ src/ipt2b_pkg.sv @@
package ipt2b_pkg;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  typedef struct packed {
    logic [15:0] hex_accum;
    logic [2:0]  hex_cnt;
    logic        dot;
    logic        err;
    logic        is_v6;
    logic [3:0]  group_count;
    logic [2:0]  empty_pos;
    logic [31:0] dotted;
  } fin_t;

  typedef struct packed {
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic [2:0]  word_count;
    logic        bad_syntax;
  } res_t;

  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

@@ src/ipt2b_front.sv @@
module ipt2b_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         ch,
  input  logic               last,
  output logic               fin_valid,
  output ipt2b_pkg::fin_t    fin,
  output logic [127:0]       groups
);
  import ipt2b_pkg::*;

  logic [15:0] gs_r [8];
  logic [15:0] gs_nxt [8];
  logic [3:0]  gc_r, gc_nxt;
  logic [2:0]  ep_r, ep_nxt;
  logic [15:0] ha_r, ha_nxt;
  logic [2:0]  hc_r, hc_nxt;
  logic [8:0]  oa_r, oa_nxt;
  logic [31:0] dv_r, dv_nxt;
  logic [1:0]  oi_r, oi_nxt;
  logic        colon_r, colon_nxt, dot_r, dot_nxt, scope_r, scope_nxt;
  logic        start_r, start_nxt, err_r, err_nxt, full_r, full_nxt;
  logic [4:0]  h;
  logic [12:0] v;

  always_comb begin
    for (int i = 0; i < 8; i++) gs_nxt[i] = gs_r[i];
    gc_nxt = gc_r; ep_nxt = ep_r; ha_nxt = ha_r; hc_nxt = hc_r;
    oa_nxt = oa_r; dv_nxt = dv_r; oi_nxt = oi_r;
    colon_nxt = colon_r; dot_nxt = dot_r; scope_nxt = scope_r;
    start_nxt = start_r; err_nxt = err_r; full_nxt = full_r;
    h = hex_of(ch);
    v = {4'd0, oa_r} * 13'd10 + {9'd0, ch[3:0]};
    if (!scope_r) begin
      start_nxt = 1'b1;
      if (ch == CH_COLON) begin
        colon_nxt = 1'b1;
        if (start_r) begin
          if (gc_r[3]) begin
            err_nxt = 1'b1;
          end else begin
            if (hc_r == 3'd0) ep_nxt = gc_r[2:0];
            if (hc_r > 3'd4 && !dot_r) err_nxt = 1'b1;
            gs_nxt[gc_r[2:0]] = ha_r;
            gc_nxt = gc_r + 4'd1;
          end
          ha_nxt = '0; hc_nxt = '0; oa_nxt = '0; dv_nxt = '0; oi_nxt = '0;
          dot_nxt = 1'b0; full_nxt = 1'b0;
        end
      end else if (ch == CH_PCT) begin
        scope_nxt = 1'b1;
      end else begin
        if (hc_r != 3'd7) hc_nxt = hc_r + 3'd1;
        if (ch == CH_DOT) begin
          if (!full_r) begin
            if (oa_r[8]) err_nxt = 1'b1;
            dv_nxt = dv_r | ({24'd0, oa_r[7:0]} << (5'd24 - {oi_r, 3'd0}));
            if (oi_r == 2'd3) full_nxt = 1'b1;
            else oi_nxt = oi_r + 2'd1;
          end
          oa_nxt = '0;
          dot_nxt = 1'b1;
        end else begin
          if (ch >= 8'h30 && ch <= 8'h39)
            oa_nxt = (v > 13'd256) ? 9'd256 : v[8:0];
          if (!h[4] && !dot_r) ha_nxt = {ha_r[11:0], h[3:0]};
        end
      end
    end
  end

  // The snapshot already holds the final octet folded into the dotted value.
  always_comb begin
    fin.hex_accum   = ha_nxt;
    fin.hex_cnt     = hc_nxt;
    fin.dot         = dot_nxt;
    fin.err         = err_nxt | (!full_nxt && oa_nxt[8] && (dot_nxt || !colon_nxt));
    fin.is_v6       = colon_nxt;
    fin.group_count = gc_nxt;
    fin.empty_pos   = ep_nxt;
    fin.dotted      = full_nxt ? dv_nxt
                    : dv_nxt | ({24'd0, oa_nxt[7:0]} << (5'd24 - {oi_nxt, 3'd0}));
    for (int i = 0; i < 8; i++) groups[127 - 16*i -: 16] = gs_nxt[i];
  end

  assign fin_valid = in_valid && last;

  always_ff @(posedge clk) begin
    if (!rst_n || fin_valid) begin
      for (int i = 0; i < 8; i++) gs_r[i] <= '0;
      gc_r <= '0; ep_r <= '0; ha_r <= '0; hc_r <= '0; oa_r <= '0;
      dv_r <= '0; oi_r <= '0;
      colon_r <= 1'b0; dot_r <= 1'b0; scope_r <= 1'b0;
      start_r <= 1'b0; err_r <= 1'b0; full_r <= 1'b0;
    end else if (in_valid) begin
      for (int i = 0; i < 8; i++) gs_r[i] <= gs_nxt[i];
      gc_r <= gc_nxt; ep_r <= ep_nxt; ha_r <= ha_nxt; hc_r <= hc_nxt;
      oa_r <= oa_nxt; dv_r <= dv_nxt; oi_r <= oi_nxt;
      colon_r <= colon_nxt; dot_r <= dot_nxt; scope_r <= scope_nxt;
      start_r <= start_nxt; err_r <= err_nxt; full_r <= full_nxt;
    end
  end

endmodule

@@ src/ipt2b_queue.sv @@
module ipt2b_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic         empty,
  output logic [W-1:0] rdata
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr && !full) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr && !full) wp_r <= !wp_r;
      if (rd && !empty) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr && !full} - {1'b0, rd && !empty};
    end
  end

endmodule

@@ src/ipt2b_back.sv @@
module ipt2b_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fin_valid,
  input  ipt2b_pkg::fin_t   fin,
  input  logic [127:0]      groups,
  output logic              q_full,
  input  logic              pop,
  output logic              empty,
  output ipt2b_pkg::res_t   res
);
  import ipt2b_pkg::*;

  logic        st_v_r;
  fin_t        st_r;
  logic [15:0] gsv_r [8];
  logic [15:0] gs [8];
  logic [15:0] g [8];
  logic [3:0]  gc, ci, lim, ins, k4;
  logic        err;
  res_t        rnew;
  logic        qfull;

  // Stage 1 registers the snapshot; stage 2 expands the gap into the queue.
  always_ff @(posedge clk) begin
    if (fin_valid) begin
      st_r <= fin;
      for (int i = 0; i < 8; i++) gsv_r[i] <= groups[127 - 16*i -: 16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_v_r <= 1'b0;
    else st_v_r <= fin_valid;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) gs[i] = gsv_r[i];
    gc  = st_r.group_count;
    err = st_r.err;
    if (st_r.is_v6 && !st_r.dot && st_r.hex_cnt != 3'd0) begin
      if (gc[3]) err = 1'b1;
      else begin
        if (st_r.hex_cnt > 3'd4) err = 1'b1;
        gs[gc[2:0]] = st_r.hex_accum;
        gc = gc + 4'd1;
      end
    end
    lim = st_r.dot ? 4'd6 : 4'd8;
    ci  = gc;
    if (gc > lim) begin
      err = 1'b1;
      ci  = lim;
    end
    ins = lim - ci;
    for (int k = 0; k < 8; k++) begin
      k4 = 4'(k);
      g[k] = '0;
      if (k4 < lim && ci != 4'd0) begin
        if (k4 <= {1'b0, st_r.empty_pos}) g[k] = (k4 < ci) ? gs[k] : '0;
        else if (k4 <= {1'b0, st_r.empty_pos} + ins) g[k] = '0;
        else g[k] = gs[3'(k4 - ins)];
      end
    end
    if (st_r.is_v6) begin
      rnew.word0 = {g[0], g[1]};
      rnew.word1 = {g[2], g[3]};
      rnew.word2 = {g[4], g[5]};
      rnew.word3 = st_r.dot ? st_r.dotted : {g[6], g[7]};
      rnew.word_count = 3'd4;
      rnew.bad_syntax = err;
    end else begin
      rnew.word0 = st_r.dotted;
      rnew.word1 = '0; rnew.word2 = '0; rnew.word3 = '0;
      rnew.word_count = 3'd1;
      rnew.bad_syntax = st_r.err;
    end
  end

  ipt2b_queue #(.W($bits(res_t))) u_q (
    .clk(clk), .rst_n(rst_n), .wr(st_v_r), .wdata(rnew), .full(qfull),
    .rd(pop), .empty(empty), .rdata(res)
  );

  // Hold input while a result is in flight and the queue may fill.
  assign q_full = qfull || (st_v_r && !empty && !pop);

endmodule

@@ src/ip_address_text_to_binary.sv @@
// Converts IPv4 or IPv6 address text to binary words.
// Input channel: one character per item on in_ch, with in_last on the final
// character; an item is taken when in_push is high and in_full is low.
// Result channel: one result per address on out_word0..out_word3,
// out_word_count (1 for IPv4, 4 for IPv6) and out_bad_syntax; the oldest
// result shows while out_empty is low and leaves when out_pop is high.
// The front end parses one character per cycle, so characters stream at one
// item per cycle while in_full is low. A result passes through a snapshot
// register, then the gap expansion into a two-entry result queue, before it
// can be popped. When the receiver stalls, in_full rises once the queue is
// full, or once it holds one result while another waits in the snapshot,
// and stays high until a result is popped.
// Synchronous reset clears all parser state and empties the queue; a partly
// received address is discarded.
module ip_address_text_to_binary (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_ch,
  input  logic        in_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_word0,
  output logic [31:0] out_word1,
  output logic [31:0] out_word2,
  output logic [31:0] out_word3,
  output logic [2:0]  out_word_count,
  output logic        out_bad_syntax
);
  import ipt2b_pkg::*;

  logic         acc, fin_valid, qf;
  fin_t         fin;
  logic [127:0] groups;
  res_t         res;

  assign acc = in_push && !in_full;
  assign in_full = qf;

  ipt2b_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(acc), .ch(in_ch), .last(in_last),
    .fin_valid(fin_valid), .fin(fin), .groups(groups)
  );

  ipt2b_back u_back (
    .clk(clk), .rst_n(rst_n), .fin_valid(fin_valid), .fin(fin), .groups(groups),
    .q_full(qf), .pop(out_pop), .empty(out_empty), .res(res)
  );

  assign out_word0      = res.word0;
  assign out_word1      = res.word1;
  assign out_word2      = res.word2;
  assign out_word3      = res.word3;
  assign out_word_count = res.word_count;
  assign out_bad_syntax = res.bad_syntax;

`ifndef ASSERT_OFF
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_word_count == 3'd1 || out_word_count == 3'd4))
    else $error("bad word count");
  a_v4: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word_count == 3'd1) |-> (out_word1 == 32'd0 && out_word3 == 32'd0))
    else $error("IPv4 result has upper words");
  a_rst: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("queue not empty after reset");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

class addr_scoreboard;
  bit [3:0]  grp_cnt;
  bit [2:0]  gap_pos;
  bit [15:0] hex_val;
  bit [2:0]  hex_len;
  bit [8:0]  oct_val;
  bit [31:0] dotted;
  bit [1:0]  oct_idx;
  bit        seen_colon, in_dot, in_scope, started, err, oct_full;
  bit [15:0] groups [8];
  bit [131:0] pending [$];
  int        mismatches;

  function void clear();
    foreach (groups[k]) groups[k] = '0;
    grp_cnt = 0; gap_pos = 0; hex_val = 0; hex_len = 0; oct_val = 0;
    dotted = 0; oct_idx = 0;
    seen_colon = 0; in_dot = 0; in_scope = 0; started = 0; err = 0; oct_full = 0;
  endfunction

  function void take_octet();
    if (!oct_full) begin
      if (oct_val > 255) err = 1;
      dotted |= 32'(oct_val[7:0]) << (24 - 8 * oct_idx);
      if (oct_idx == 3) oct_full = 1;
      else oct_idx++;
    end
    oct_val = 0;
  endfunction

  function void close_group();
    if (grp_cnt >= 8) begin
      err = 1;
    end else begin
      if (hex_len == 0) gap_pos = grp_cnt[2:0];
      if (hex_len > 4 && !in_dot) err = 1;
      groups[grp_cnt[2:0]] = hex_val;
      grp_cnt++;
    end
    hex_val = 0; hex_len = 0; oct_val = 0; dotted = 0; oct_idx = 0;
    in_dot = 0; oct_full = 0;
  endfunction

  function void note_char(bit [7:0] c, bit last);
    int h, v, ci, lim, ins;
    bit first, tail;
    bit [31:0] w [4];
    bit [31:0] tail_val;
    bit [15:0] g [8];
    h = -1;
    if (c >= "0" && c <= "9") h = c - "0";
    else if (c >= "a" && c <= "f") h = c - "a" + 10;
    else if (c >= "A" && c <= "F") h = c - "A" + 10;
    if (!in_scope) begin
      first = !started;
      started = 1;
      if (c == ipt2b_pkg::CH_COLON) begin
        seen_colon = 1;
        if (!first) close_group();
      end else if (c == ipt2b_pkg::CH_PCT) begin
        in_scope = 1;
      end else begin
        if (hex_len < 7) hex_len++;
        if (c == ipt2b_pkg::CH_DOT) begin
          take_octet();
          in_dot = 1;
        end else begin
          if (c >= "0" && c <= "9") begin
            v = oct_val * 10 + (c - "0");
            oct_val = 9'((v > 256) ? 256 : v);
          end
          if (h >= 0 && !in_dot) hex_val = {hex_val[11:0], 4'(h)};
        end
      end
    end
    if (!last) return;
    foreach (w[k]) w[k] = 0;
    if (!seen_colon) begin
      take_octet();
      w[0] = dotted;
      pending.push_back({w[0], w[1], w[2], w[3], 3'd1, err});
    end else begin
      tail = in_dot;
      tail_val = 0;
      if (tail) begin
        take_octet();
        tail_val = dotted;
      end else if (hex_len > 0) begin
        close_group();
      end
      lim = tail ? 6 : 8;
      ci = grp_cnt;
      if (ci > lim) begin
        err = 1;
        ci = lim;
      end
      ins = lim - ci;
      foreach (g[k]) g[k] = 0;
      for (int k = 0; k < lim; k++) begin
        if (ci == 0) g[k] = 0;
        else if (k <= gap_pos) g[k] = (k < ci) ? groups[k] : 0;
        else if (k <= gap_pos + ins) g[k] = 0;
        else g[k] = groups[(k - ins) & 7];
      end
      for (int k = 0; k < 4; k++) w[k] = {g[2*k], g[2*k+1]};
      if (tail) w[3] = tail_val;
      pending.push_back({w[0], w[1], w[2], w[3], 3'd4, err});
    end
    clear();
  endfunction

  function void check_result(bit [131:0] got);
    bit [131:0] exp;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected address result %h", got);
      return;
    end
    exp = pending.pop_front();
    if (exp !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Address result mismatch: expected %h actual %h", exp, got);
    end
  endfunction
endclass

module tb_top;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_push = 0;
  logic        in_full;
  logic [7:0]  in_ch = 0;
  logic        in_last = 0;
  logic        out_empty;
  logic        out_pop = 0;
  logic [31:0] out_word0, out_word1, out_word2, out_word3;
  logic [2:0]  out_word_count;
  logic        out_bad_syntax;

  addr_scoreboard sb = new();
  int  cycle_count = 0;
  int  hold_off = 0;
  bit  hold_go = 0;
  bit  hold_used = 0;
  bit  no_idle = 0;
  bit  stim_done = 0;

  ip_address_text_to_binary dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_result({out_word0, out_word1, out_word2, out_word3,
                       out_word_count, out_bad_syntax});
    if (hold_go && !hold_used) begin
      hold_used <= 1;
      hold_off <= 200;
      out_pop <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_pop <= 0;
    end else begin
      out_pop <= no_idle || ($urandom_range(99) >= 24);
    end
  end

  task automatic send_char(bit [7:0] c, bit last);
    while (!no_idle && $urandom_range(99) < 24) begin
      in_push <= 0;
      @(posedge clk);
    end
    in_push <= 1;
    in_ch <= c;
    in_last <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_char(c, last);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic string hex_group(int n);
    string s, d;
    s = "";
    d = "0123456789abcdefABCDEF";
    for (int i = 0; i < n; i++) s = {s, string'(d[$urandom_range(21)])};
    return s;
  endfunction

  function automatic string rand_addr();
    string s, alpha;
    int n, gap;
    alpha = "0123456789abcdef:.%";
    case ($urandom_range(9))
      0, 1, 2: begin
        s = $sformatf("%0d.%0d.%0d.%0d", $urandom_range(260), $urandom_range(255),
                      $urandom_range(255), $urandom_range(300));
      end
      3, 4, 5, 6: begin
        n = $urandom_range(9);
        gap = $urandom_range(n);
        s = "";
        for (int i = 0; i < n; i++) begin
          if (i == gap && $urandom_range(1)) s = {s, ":"};
          s = {s, hex_group($urandom_range(5) == 0 ? 5 : $urandom_range(1, 4))};
          if (i < n - 1) s = {s, ":"};
        end
        if (n < 2) s = {"::", s};
        if ($urandom_range(3) == 0)
          s = {s, $sformatf(":%0d.%0d.%0d.%0d", $urandom_range(255), $urandom_range(255),
                            $urandom_range(255), $urandom_range(256))};
        if ($urandom_range(5) == 0) s = {s, "%eth", hex_group(2), ":"};
      end
      default: begin
        n = $urandom_range(1, 12);
        s = "";
        for (int i = 0; i < n; i++)
          s = {s, string'($urandom_range(3) ? alpha[$urandom_range(18)]
                                           : 8'($urandom_range(255)))};
      end
    endcase
    return s;
  endfunction

  task automatic drain();
    in_push <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    string directed [$];
    int sent;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    directed = '{"0.0.0.0", "255.255.255.255", "256.1.2.3", "1.2", "1.2.3.4.5",
                 "::", "::1", "1::", "ffff:FFFF:ffff:ffff:ffff:ffff:ffff:ffff",
                 "1:2:3:4:5:6:7:8:9", "12345::1", "::ffff:192.168.1.1",
                 "1:2:3:4:5:6:7:1.2.3.4", "fe80::1%eth0:x", "1.2.3.4%a:b",
                 ":", "a:", "1.2::3", "1..2", "%", "g:z", "1::2::3", "1::300"};
    foreach (directed[i]) send_text(directed[i]);
    send_char(8'h00, 0);
    send_char(8'hff, 1);
    send_char(8'h80, 1);
    drain();
    sent = 0;
    while (sent < 1000) begin
      string a;
      a = rand_addr();
      send_text(a);
      sent += a.len();
      if (sent > 300 && !hold_go) begin
        hold_go = 1;
        no_idle = 1;
      end
      if (sent > 500 && no_idle) begin
        drain();
        no_idle = 0;
      end
    end
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
